[src/kpd_pkg.sv]
package kpd_pkg;

  // Operation codes on the input word
  localparam logic [1:0] OP_SCAN  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  // Key code 0..15 is row*4+column; this one means nothing pressed
  localparam logic [4:0] NO_KEY = 5'd16;

  // Decoded command kinds passed from front to back
  typedef enum logic [1:0] {
    CMD_SCAN,
    CMD_READ,
    CMD_FLUSH,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  cols;
  } cmd_t;

  // Keypad legend, row 0 "123A" .. row 3 "*0#D"
  function automatic logic [7:0] key_ascii(input logic [3:0] code);
    logic [7:0] ch;
    case (code)
      4'd0:    ch = 8'h31;
      4'd1:    ch = 8'h32;
      4'd2:    ch = 8'h33;
      4'd3:    ch = 8'h41;
      4'd4:    ch = 8'h34;
      4'd5:    ch = 8'h35;
      4'd6:    ch = 8'h36;
      4'd7:    ch = 8'h42;
      4'd8:    ch = 8'h37;
      4'd9:    ch = 8'h38;
      4'd10:   ch = 8'h39;
      4'd11:   ch = 8'h43;
      4'd12:   ch = 8'h2A;
      4'd13:   ch = 8'h30;
      4'd14:   ch = 8'h23;
      4'd15:   ch = 8'h44;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[src/kpd_front.sv]
module kpd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [1:0]     operation,
  input  logic [3:0]     column_lines,
  output logic           cmd_valid,
  output kpd_pkg::cmd_t  cmd,
  input  logic           cmd_take
);
  import kpd_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_cnt;
  logic       enq;
  logic       deq;
  cmd_t       decoded;

  // Classify the incoming word
  always_comb begin
    decoded.cols = column_lines;
    case (operation)
      OP_SCAN:  decoded.kind = CMD_SCAN;
      OP_READ:  decoded.kind = CMD_READ;
      OP_FLUSH: decoded.kind = CMD_FLUSH;
      default:  decoded.kind = CMD_NOP;
    endcase
  end

  assign full      = (q_cnt == 2'd2);
  assign enq       = push && !full;
  assign cmd_valid = (q_cnt != 2'd0);
  assign deq       = cmd_take && cmd_valid;
  assign cmd       = q[rd_ptr];

  // Two-entry command queue
  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= !wr_ptr;
      end
      if (deq) begin
        rd_ptr <= !rd_ptr;
      end
      case ({enq, deq})
        2'b10:   q_cnt <= q_cnt + 2'd1;
        2'b01:   q_cnt <= q_cnt - 2'd1;
        default: q_cnt <= q_cnt;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_qcnt_range: assert property (@(posedge clk) disable iff (rst) q_cnt <= 2'd2)
    else $error("command queue count out of range");
  a_qcnt_grow: assert property (@(posedge clk) disable iff (rst)
    (enq && !deq) |=> (q_cnt == $past(q_cnt) + 2'd1))
    else $error("command queue lost an entry");
`endif

endmodule

[src/kpd_back.sv]
module kpd_back #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  kpd_pkg::cmd_t  cmd,
  output logic           cmd_take,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [7:0]     cfg_data,
  output logic           empty,
  input  logic           pop,
  output logic [1:0]     row_drive,
  output logic           key_valid,
  output logic [7:0]     key_char,
  output logic [4:0]     keys_waiting,
  output logic           key_dropped
);
  import kpd_pkg::*;

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  // Scanner and debounce state
  logic [7:0]    debounce_scans;
  logic [1:0]    current_row, current_row_next;
  logic [4:0]    scan_key, scan_key_next;
  logic [4:0]    last_change_key, last_change_key_next;
  logic [4:0]    stable_key, stable_key_next;
  logic [7:0]    stable_scans, stable_scans_next;
  logic [7:0]    scans_inc;
  logic [4:0]    row_key;
  logic [4:0]    scan_result;

  // Key buffer
  logic [3:0]    key_store [FIFO_DEPTH];
  logic [PW-1:0] write_pointer, write_pointer_next;
  logic [PW-1:0] read_pointer, read_pointer_next;
  logic [CW-1:0] key_count, key_count_next;
  logic [3:0]    rd_code;

  // Result register
  logic          res_valid;
  logic [1:0]    res_row;
  logic          res_key_valid;
  logic [4:0]    res_count;
  logic          res_drop;

  logic          go;
  logic          do_push;
  logic          do_pop;
  logic          drop;

  assign go        = cmd_valid && (!res_valid || pop);
  assign cmd_take  = go;
  assign cfg_ready = 1'b1;

  // Lowest pressed column of the driven row
  always_comb begin
    row_key = scan_key;
    for (int c = 3; c >= 0; c--) begin
      if (!cmd.cols[c]) begin
        row_key = {1'b0, current_row, 2'(c)};
      end
    end
  end

  assign scans_inc = (stable_scans != 8'hFF) ? stable_scans + 8'd1 : stable_scans;

  // Execute one command
  always_comb begin
    current_row_next     = current_row;
    scan_key_next        = scan_key;
    last_change_key_next = last_change_key;
    stable_key_next      = stable_key;
    stable_scans_next    = stable_scans;
    write_pointer_next   = write_pointer;
    read_pointer_next    = read_pointer;
    key_count_next       = key_count;
    scan_result          = row_key;
    do_push              = 1'b0;
    do_pop               = 1'b0;
    drop                 = 1'b0;
    case (cmd.kind)
      CMD_SCAN: begin
        if (current_row == 2'd3) begin
          // end of a full scan: debounce
          current_row_next = 2'd0;
          scan_key_next    = NO_KEY;
          if (scan_result == last_change_key) begin
            if (scans_inc >= debounce_scans) begin
              if (scan_result != NO_KEY && stable_key == NO_KEY) begin
                if (key_count < CW'(FIFO_DEPTH)) begin
                  do_push = 1'b1;
                end else begin
                  drop = 1'b1;
                end
              end
              stable_key_next   = scan_result;
              stable_scans_next = 8'd0;
            end else begin
              stable_scans_next = scans_inc;
            end
          end else begin
            stable_scans_next    = 8'd0;
            last_change_key_next = scan_result;
          end
        end else begin
          current_row_next = current_row + 2'd1;
          scan_key_next    = scan_result;
        end
      end
      CMD_READ: begin
        if (key_count != '0) begin
          do_pop = 1'b1;
        end
      end
      CMD_FLUSH: begin
        write_pointer_next = '0;
        read_pointer_next  = '0;
        key_count_next     = '0;
      end
      default: begin
      end
    endcase
    if (do_push) begin
      write_pointer_next = (write_pointer == PW'(FIFO_DEPTH - 1)) ? '0 :
                           write_pointer + PW'(1);
      key_count_next     = key_count + CW'(1);
    end
    if (do_pop) begin
      read_pointer_next = (read_pointer == PW'(FIFO_DEPTH - 1)) ? '0 :
                          read_pointer + PW'(1);
      key_count_next    = key_count - CW'(1);
    end
  end

  // Key store, registered read at the read pointer
  always_ff @(posedge clk) begin
    if (go && do_push) begin
      key_store[write_pointer] <= scan_result[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rd_code <= key_store[read_pointer];
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_scans <= 8'd4;
    end else if (cfg_valid) begin
      debounce_scans <= cfg_data;
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      current_row     <= 2'd0;
      scan_key        <= NO_KEY;
      last_change_key <= NO_KEY;
      stable_key      <= NO_KEY;
      stable_scans    <= 8'd0;
      write_pointer   <= '0;
      read_pointer    <= '0;
      key_count       <= '0;
    end else if (go) begin
      current_row     <= current_row_next;
      scan_key        <= scan_key_next;
      last_change_key <= last_change_key_next;
      stable_key      <= stable_key_next;
      stable_scans    <= stable_scans_next;
      write_pointer   <= write_pointer_next;
      read_pointer    <= read_pointer_next;
      key_count       <= key_count_next;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_row       <= current_row_next;
      res_key_valid <= do_pop;
      res_count     <= 5'(key_count_next);
      res_drop      <= drop;
    end
  end

  assign empty        = !res_valid;
  assign row_drive    = res_row;
  assign key_valid    = res_key_valid;
  assign key_char     = res_key_valid ? key_ascii(rd_code) : 8'h00;
  assign keys_waiting = res_count;
  assign key_dropped  = res_drop;

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    key_count <= CW'(FIFO_DEPTH))
    else $error("key count above buffer depth");
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (go && cmd.kind == CMD_FLUSH) |=>
      (key_count == '0 && write_pointer == '0 && read_pointer == '0))
    else $error("flush left keys in the buffer");
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (go && drop) |-> (key_count == CW'(FIFO_DEPTH)))
    else $error("key dropped with room in the buffer");
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !pop) |=> (res_valid && $stable(key_char) && $stable(res_count)))
    else $error("waiting result changed");
`endif

endmodule

[src/matrix_keypad_scan_debounce_fifo.sv]
// Channel   Handshake                 Payload
// input     push / full               operation, column_lines
// result    empty / pop               row_drive, key_valid, key_char, keys_waiting, key_dropped
// config    cfg_valid / cfg_ready     cfg_data (debounce_scans)
//
// One word per cycle while results are popped; a word is queued, then its result is registered.
// The front holds a two-entry command queue, so full depends on that queue only.
// The back executes one command per cycle whenever the result register is free or popped.
// Key store is read through a registered port at the read pointer.
// Synchronous reset clears all control state; debounce_scans resets to 4.
module matrix_keypad_scan_debounce_fifo #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] operation,
  input  logic [3:0] column_lines,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] row_drive,
  output logic       key_valid,
  output logic [7:0] key_char,
  output logic [4:0] keys_waiting,
  output logic       key_dropped,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import kpd_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  kpd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .operation    (operation),
    .column_lines (column_lines),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  kpd_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .empty        (empty),
    .pop          (pop),
    .row_drive    (row_drive),
    .key_valid    (key_valid),
    .key_char     (key_char),
    .keys_waiting (keys_waiting),
    .key_dropped  (key_dropped)
  );

endmodule

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kpd_pkg::*;

  // Operation code the block leaves unused
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int KEY_RING_DEPTH = 16;
  localparam string KEY_LEGEND = "123A456B789C*0#D";

  // One result word, fields in port order
  typedef struct packed {
    logic [1:0] row_drive;
    logic       key_valid;
    logic [7:0] key_char;
    logic [4:0] keys_waiting;
    logic       key_dropped;
  } kp_report_t;

  localparam kp_report_t QUIET_REPORT = '0;

  // Directed row: quiet marks an all-zero result typed in by hand
  typedef struct packed {
    logic [1:0] op;
    logic [3:0] cols;
    logic       quiet;
  } stim_row_t;

  // Debounce set to 1 for this table; col pattern 0111 presses column 3 only
  localparam stim_row_t DIRECTED [22] = '{
    '{OP_READ,   4'hF,    1'b1},  // read on empty buffer after reset
    '{OP_UNUSED, 4'h0,    1'b1},
    '{OP_FLUSH,  4'h0,    1'b1},
    '{OP_SCAN,   4'b0000, 1'b0},  // row 0, all columns: lowest wins
    '{OP_SCAN,   4'hF,    1'b0},
    '{OP_SCAN,   4'b0111, 1'b0},  // row 2 col 3 overrides row 0
    '{OP_SCAN,   4'hF,    1'b0},
    '{OP_SCAN,   4'hF,    1'b0},
    '{OP_SCAN,   4'hF,    1'b0},
    '{OP_SCAN,   4'b0111, 1'b0},
    '{OP_SCAN,   4'hF,    1'b0},  // second equal scan pushes the key
    '{OP_READ,   4'h0,    1'b0},
    '{OP_READ,   4'hF,    1'b1},
    '{OP_SCAN,   4'hF,    1'b0},
    '{OP_SCAN,   4'hF,    1'b0},
    '{OP_SCAN,   4'hF,    1'b0},
    '{OP_SCAN,   4'hF,    1'b0},
    '{OP_SCAN,   4'hF,    1'b0},
    '{OP_SCAN,   4'hF,    1'b0},
    '{OP_SCAN,   4'hF,    1'b0},
    '{OP_SCAN,   4'hF,    1'b0},
    '{OP_UNUSED, 4'hF,    1'b1}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] operation = OP_SCAN;
  logic [3:0] column_lines = 4'hF;
  logic       empty;
  logic       pop = 1'b0;
  logic [1:0] row_drive;
  logic       key_valid;
  logic [7:0] key_char;
  logic [4:0] keys_waiting;
  logic       key_dropped;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'd0;

  matrix_keypad_scan_debounce_fifo uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .operation    (operation),
    .column_lines (column_lines),
    .empty        (empty),
    .pop          (pop),
    .row_drive    (row_drive),
    .key_valid    (key_valid),
    .key_char     (key_char),
    .keys_waiting (keys_waiting),
    .key_dropped  (key_dropped),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Keypad state mirror, at reset values
  logic [7:0] debounce_setting = 8'd4;
  logic [1:0] drive_row = 2'd0;
  logic [4:0] scan_code = NO_KEY;
  logic [4:0] changed_code = NO_KEY;
  logic [4:0] settled_code = NO_KEY;
  logic [7:0] settle_count = 8'd0;
  logic [3:0] key_ring [KEY_RING_DEPTH];
  logic [3:0] ring_wr = 4'd0;
  logic [3:0] ring_rd = 4'd0;
  logic [4:0] ring_fill = 5'd0;

  kp_report_t report_due [$];
  int mismatches = 0;
  int push_run = 0;
  int pop_run = 0;

  // Wait before the next word; occasional runs with no gaps at all
  function automatic int draw_gap(inout int run);
    if (run == 0 && $urandom_range(0, 19) == 0) run = $urandom_range(8, 60);
    if (run != 0) begin
      run--;
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  // Apply one word to the mirror and form the result it should give
  task automatic advance_keypad(input logic [1:0] op, input logic [3:0] cols,
                                output kp_report_t rep);
    logic found;
    logic dropped;
    rep = '0;
    dropped = 1'b0;
    found = 1'b0;
    case (op)
      OP_SCAN: begin
        for (int c = 0; c < 4; c++) begin
          if (!found && !cols[c]) begin
            scan_code = {1'b0, drive_row, 2'(c)};
            found = 1'b1;
          end
        end
        if (drive_row == 2'd3) begin
          // full scan done: debounce the scan result
          drive_row = 2'd0;
          if (scan_code == changed_code) begin
            if (settle_count != 8'hFF) settle_count++;
            if (settle_count >= debounce_setting) begin
              if (scan_code != NO_KEY && settled_code == NO_KEY) begin
                if (ring_fill >= KEY_RING_DEPTH) begin
                  dropped = 1'b1;
                end else begin
                  key_ring[ring_wr] = scan_code[3:0];
                  ring_wr++;
                  ring_fill++;
                end
              end
              settled_code = scan_code;
              settle_count = 8'd0;
            end
          end else begin
            settle_count = 8'd0;
            changed_code = scan_code;
          end
          scan_code = NO_KEY;
        end else begin
          drive_row++;
        end
      end
      OP_READ: begin
        if (ring_fill != 0) begin
          rep.key_valid = 1'b1;
          rep.key_char = KEY_LEGEND[key_ring[ring_rd]];
          ring_rd++;
          ring_fill--;
        end
      end
      OP_FLUSH: begin
        ring_wr = 4'd0;
        ring_rd = 4'd0;
        ring_fill = 5'd0;
      end
      default: ;
    endcase
    rep.row_drive = drive_row;
    rep.keys_waiting = ring_fill;
    rep.key_dropped = dropped;
  endtask

  // Entered and left at a falling edge
  task automatic send_word(input logic [1:0] op, input logic [3:0] cols, input logic quiet);
    int gap;
    kp_report_t rep;
    gap = draw_gap(push_run);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    operation <= op;
    column_lines <= cols;
    do @(posedge clk); while (full);
    advance_keypad(op, cols, rep);
    report_due.push_back(quiet ? QUIET_REPORT : rep);
    @(negedge clk);
  endtask

  // Register write only with the pipeline drained
  task automatic write_debounce(input logic [7:0] value);
    push <= 1'b0;
    while (report_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    debounce_setting = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random keypad activity: held key patterns with bounce, reads and flushes
  // mixed in; rates are per mille. Alternate mode toggles one key and release.
  task automatic run_phase(input logic [7:0] deb, input int words, input int read_pm,
                           input bit alternate);
    int sent;
    int scans_left;
    int needed;
    int roll;
    logic [15:0] held;
    logic [3:0] cols;
    logic [1:0] op;
    write_debounce(deb);
    needed = (deb == 0) ? 2 : int'(deb) + 1;
    held = '0;
    scans_left = 0;
    sent = 0;
    while (sent < words) begin
      if (scans_left == 0 && drive_row == 2'd0) begin
        if (alternate) begin
          held = (held != 0) ? 16'h0 : 16'(1 << $urandom_range(0, 15));
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 55) held = 16'(1 << $urandom_range(0, 15));
          else if (roll < 75) held = 16'($urandom);
          else held = 16'h0;
        end
        scans_left = needed + $urandom_range(0, 2);
        // short hold that may end before the key settles
        if (!alternate && $urandom_range(0, 7) == 0) scans_left = $urandom_range(1, needed);
      end
      roll = $urandom_range(0, 999);
      cols = 4'($urandom);
      if (roll < read_pm) begin
        op = OP_READ;
      end else if (roll < read_pm + 2) begin
        op = OP_FLUSH;
      end else if (roll < read_pm + 10) begin
        op = OP_UNUSED;
      end else begin
        op = OP_SCAN;
        if ($urandom_range(0, 24) != 0) cols = ~held[drive_row*4 +: 4];
      end
      send_word(op, cols, 1'b0);
      sent++;
      if (op == OP_SCAN && drive_row == 2'd0 && scans_left != 0) scans_left--;
    end
  endtask

  task automatic note_failure(input string what, input kp_report_t got, input kp_report_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: got row %0d valid %0d char %02h waiting %0d dropped %0d", what,
               got.row_drive, got.key_valid, got.key_char, got.keys_waiting, got.key_dropped);
      $display("  expected row %0d valid %0d char %02h waiting %0d dropped %0d",
               want.row_drive, want.key_valid, want.key_char, want.keys_waiting,
               want.key_dropped);
    end
  endtask

  // Result side: random pop gaps, compare each word with the oldest pending one
  initial begin : result_check
    int gap;
    kp_report_t got;
    kp_report_t want;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      gap = draw_gap(pop_run);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got = {row_drive, key_valid, key_char, keys_waiting, key_dropped};
      if (report_due.size() == 0) begin
        note_failure("result word with nothing pending", got, QUIET_REPORT);
      end else begin
        want = report_due.pop_front();
        if (got !== want) note_failure("result word mismatch", got, want);
      end
      @(negedge clk);
    end
  end

  // Stimulus
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_debounce(8'd1);
    for (int i = 0; i < $size(DIRECTED); i++) begin
      send_word(DIRECTED[i].op, DIRECTED[i].cols, DIRECTED[i].quiet);
    end

    run_phase(8'd1, 250, 150, 1'b0);
    run_phase(8'd0, 700, 10, 1'b0);      // few reads: buffer fills and drops keys
    run_phase(8'd255, 600, 30, 1'b1);    // longest debounce
    run_phase(8'd4, 250, 200, 1'b0);
    run_phase(8'($urandom_range(2, 12)), 200, 150, 1'b0);

    push <= 1'b0;
    while (report_due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("matrix_keypad_scan_debounce_fifo verification clean");
    end else begin
      $display("matrix_keypad_scan_debounce_fifo verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("matrix_keypad_scan_debounce_fifo verification failed");
    $finish;
  end

endmodule
